[rtl/core/awps_pkg.sv]
// ----------------------------------------------------------------------------
// awps_pkg
// shared constants, types and codes for the aligned wildcard pattern scan
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package awps_pkg;

  // sizing
  localparam int MAX_PATTERN = 64;
  localparam int STRIDE      = 4;
  localparam int ADDR_BITS   = 32;

  localparam int PAT_AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
  localparam int SMW    = (STRIDE > 1) ? $clog2(STRIDE) : 1;
  localparam int IDX_W  = 32;

  localparam logic [SMW-1:0]   STRIDE_TOP = SMW'(STRIDE - 1);
  localparam logic [LEN_W-1:0] LEN_MAX    = LEN_W'(MAX_PATTERN);
  localparam logic [IDX_W-1:0] IDX_LIMIT  = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF :
                                            32'((64'd1 << ADDR_BITS) - 64'd1);

  localparam logic [7:0] WILDCARD_BYTE = 8'h2A;

  // opcode values
  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_REGION  = 1'b1;

  // payload widths on the streams
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;

  // control handed to every cell of the row
  typedef struct packed {
    logic win_shift;   // move the region byte window one cell along
    logic pat_shift;   // move the aligned pattern one cell along
    logic mask_clr;    // drop all pattern masks before a rebuild
  } cell_ctl_t;

endpackage

[rtl/core/awps_ram.sv]
// ----------------------------------------------------------------------------
// awps_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module awps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/awps_cell.sv]
// ----------------------------------------------------------------------------
// awps_cell
// one cell of the scan row: a window byte, an aligned pattern byte and its mask
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module awps_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  awps_pkg::cell_ctl_t ctl,
  input  logic [7:0]          win_i,
  input  logic [7:0]          pat_i,
  input  logic                mask_i,
  output logic [7:0]          win_o,
  output logic [7:0]          pat_o,
  output logic                mask_o,
  output logic                hit_o
);
  import awps_pkg::*;

  logic [7:0] win_r;
  logic [7:0] pat_r;
  logic       mask_r;

  // payload bytes, no reset needed
  always_ff @(posedge clk) begin
    if (ctl.win_shift) begin
      win_r <= win_i;
    end
    if (ctl.pat_shift) begin
      pat_r <= pat_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= 1'b0;
    end else if (ctl.mask_clr) begin
      mask_r <= 1'b0;
    end else if (ctl.pat_shift) begin
      mask_r <= mask_i;
    end
  end

  // unused position, wildcard or equal byte
  assign hit_o  = !mask_r || (pat_r == WILDCARD_BYTE) || (pat_r == win_r);
  assign win_o  = win_r;
  assign pat_o  = pat_r;
  assign mask_o = mask_r;

endmodule

[rtl/core/aligned_wildcard_pattern_scan.sv]
// ----------------------------------------------------------------------------
// aligned_wildcard_pattern_scan
// finds the first stride-aligned start of a wildcard byte pattern in a region
// ----------------------------------------------------------------------------
//
// channel  | direction | contents
// ---------+-----------+------------------------------------------------------
// in_      | slave     | tuser opcode, tdata data_byte, tlast last
// out_     | master    | tdata found (bit 0), match_offset (bits 32:1)
//
// region bytes stream at one byte a cycle while the input is not stalled
// a pattern byte needs no further work, unless it ends a pattern or overwrites a
// byte of the active pattern; then the pattern ram is walked once to realign
// the cell row, and the next transfer waits until the walk is done
// synchronous active-low reset; no clearing pass, the pattern ram needs none
// input stalls while the row is realigned and while a result waits unread
//
// the row holds the last MAX_PATTERN region bytes (cell k = k+1 bytes back)
// beside the pattern stored reversed, so cell k always faces the pattern byte
// that lines up with it for the start position tested by the current byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aligned_wildcard_pattern_scan (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [awps_pkg::IN_TDATA_W-1:0]  in_tdata,   // data_byte
  input  logic                             in_tuser,   // opcode
  input  logic                             in_tlast,   // last
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [awps_pkg::OUT_TDATA_W-1:0] out_tdata   // found, match_offset, zero fill
);
  import awps_pkg::*;

  localparam logic ST_IDLE    = 1'b0;
  localparam logic ST_REBUILD = 1'b1;

  logic state_r, state_nxt;

  // pattern bookkeeping
  logic [LEN_W-1:0] fill_r, fill_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [SMW-1:0]   lmod_r, lmod_nxt;    // pattern length mod stride

  // realign walk over the pattern ram
  logic [LEN_W-1:0] rb_cnt_r, rb_cnt_nxt;
  logic             rd_vld_r, rd_vld_nxt;

  // region state
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [SMW-1:0]   bmod_r, bmod_nxt;    // byte index mod stride
  logic             seen_r, seen_nxt;
  logic [IDX_W-1:0] first_r, first_nxt;

  // result register
  logic             out_vld_r, out_vld_nxt;
  logic             out_found_r, out_found_nxt;
  logic [IDX_W-1:0] out_off_r, out_off_nxt;

  logic             acc, acc_pat, acc_reg;
  logic             pat_we, rb_re;
  logic [7:0]       rd_data;
  logic [LEN_W-1:0] fill_inc;
  logic             in_range, test_hit, all_hit;
  logic [IDX_W-1:0] start_pos;
  cell_ctl_t        ctl;

  logic [7:0]       win_chain  [MAX_PATTERN+1];
  logic [7:0]       pat_chain  [MAX_PATTERN+1];
  logic             mask_chain [MAX_PATTERN+1];
  logic [MAX_PATTERN-1:0] hit_vec;
  logic [MAX_PATTERN-1:0] mask_vec;

  assign in_tready = (state_r == ST_IDLE) && (!out_vld_r || out_tready);
  assign acc       = in_tvalid && in_tready;
  assign acc_pat   = acc && (in_tuser == OP_PATTERN);
  assign acc_reg   = acc && (in_tuser == OP_REGION);

  // pattern ram: written by pattern transfers, read by the realign walk
  assign pat_we   = acc_pat && (fill_r < LEN_MAX);
  assign rb_re    = (state_r == ST_REBUILD) && (rb_cnt_r < len_r);
  assign fill_inc = fill_r + LEN_W'(1);

  awps_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PATTERN)
  ) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (fill_r[PAT_AW-1:0]),
    .wdata (in_tdata[7:0]),
    .re    (rb_re),
    .raddr (rb_cnt_r[PAT_AW-1:0]),
    .rdata (rd_data)
  );

  // cell row
  assign in_range      = (idx_r < IDX_LIMIT);
  assign ctl.win_shift = acc_reg && in_range;
  assign ctl.pat_shift = rd_vld_r;
  assign ctl.mask_clr  = 1'b0;

  assign win_chain[0]  = in_tdata[7:0];
  assign pat_chain[0]  = rd_data;
  assign mask_chain[0] = 1'b1;

  cell_ctl_t ctl_row;
  always_comb begin
    ctl_row          = ctl;
    ctl_row.mask_clr = (state_r == ST_IDLE) && (state_nxt == ST_REBUILD);
  end

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    awps_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl_row),
      .win_i  (win_chain[k]),
      .pat_i  (pat_chain[k]),
      .mask_i (mask_chain[k]),
      .win_o  (win_chain[k+1]),
      .pat_o  (pat_chain[k+1]),
      .mask_o (mask_chain[k+1]),
      .hit_o  (hit_vec[k])
    );
    assign mask_vec[k] = mask_chain[k+1];
  end

  assign all_hit   = &hit_vec;
  assign start_pos = idx_r - IDX_W'(len_r);
  // start tested by this byte: aligned, fully inside the region, not yet found
  assign test_hit  = in_range && !seen_r && (idx_r >= IDX_W'(len_r)) &&
                     (bmod_r == lmod_r) && all_hit;

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    len_nxt       = len_r;
    lmod_nxt      = lmod_r;
    rb_cnt_nxt    = rb_cnt_r;
    rd_vld_nxt    = 1'b0;
    idx_nxt       = idx_r;
    bmod_nxt      = bmod_r;
    seen_nxt      = seen_r;
    first_nxt     = first_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_found_nxt = out_found_r;
    out_off_nxt   = out_off_r;

    unique case (state_r)
      ST_IDLE: begin
        if (acc_pat) begin
          if (fill_r < LEN_MAX) begin
            fill_nxt = fill_inc;
          end
          if (in_tlast) begin
            len_nxt   = (fill_r < LEN_MAX) ? fill_inc : fill_r;
            fill_nxt  = '0;
            state_nxt = ST_REBUILD;
          end else if ((fill_r < LEN_MAX) && (fill_r < len_r)) begin
            // active pattern byte overwritten
            state_nxt = ST_REBUILD;
          end
          // a realign recounts the length phase from the start
          if (state_nxt == ST_REBUILD) begin
            rb_cnt_nxt = '0;
            lmod_nxt   = '0;
          end
        end
        if (acc_reg) begin
          if (in_range) begin
            if (test_hit) begin
              seen_nxt  = 1'b1;
              first_nxt = start_pos;
            end
            idx_nxt  = idx_r + IDX_W'(1);
            bmod_nxt = (bmod_r == STRIDE_TOP) ? '0 : bmod_r + SMW'(1);
          end
          if (in_tlast) begin
            out_vld_nxt   = 1'b1;
            out_found_nxt = seen_r || test_hit;
            out_off_nxt   = seen_r ? first_r : (test_hit ? start_pos : '0);
            idx_nxt       = '0;
            bmod_nxt      = '0;
            seen_nxt      = 1'b0;
            first_nxt     = '0;
          end
        end
      end
      ST_REBUILD: begin
        if (rb_re) begin
          rb_cnt_nxt = rb_cnt_r + LEN_W'(1);
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r) begin
          lmod_nxt = (lmod_r == STRIDE_TOP) ? '0 : lmod_r + SMW'(1);
        end
        if ((rb_cnt_r == len_r) && !rd_vld_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      fill_r    <= '0;
      len_r     <= '0;
      lmod_r    <= '0;
      rb_cnt_r  <= '0;
      rd_vld_r  <= 1'b0;
      idx_r     <= '0;
      bmod_r    <= '0;
      seen_r    <= 1'b0;
      first_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      len_r     <= len_nxt;
      lmod_r    <= lmod_nxt;
      rb_cnt_r  <= rb_cnt_nxt;
      rd_vld_r  <= rd_vld_nxt;
      idx_r     <= idx_nxt;
      bmod_r    <= bmod_nxt;
      seen_r    <= seen_nxt;
      first_r   <= first_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
    out_off_r   <= out_off_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_TDATA_W - IDX_W - 1){1'b0}}, out_off_r, out_found_r};

  // assertions

  // no transfer is taken while the row is being realigned
  a_no_accept_in_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REBUILD) |-> !in_tready)
    else $error("input accepted during realign");

  // a finished realign leaves exactly pattern-length masks set
  a_mask_matches_len: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_IDLE) && $past(state_r == ST_REBUILD)) |->
      ($countones(mask_vec) == int'(len_r)))
    else $error("mask count differs from pattern length");

  // no match means a zero offset
  a_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_found_r) |-> (out_off_r == '0))
    else $error("offset set without a match");

  // recorded match holds between region transfers
  a_match_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (seen_r && !acc_reg) |=> (seen_r && $stable(first_r)))
    else $error("match record changed without a region transfer");

endmodule
